// ===== rtl/lzss_pkg.sv =====
// ============================================================================
// lzss_pkg
// Shared types and codes for the LZSS ring-window decompressor.
// ============================================================================
`default_nettype none

package lzss_pkg;

    // input function codes
    localparam logic [1:0] FUNC_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_BYTE  = 2'd1;
    localparam logic [1:0] FUNC_END   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_OVF = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOG2   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HI_SHIFT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_HIGH_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MASK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT     = 3'd5;

    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam int WLOG2_RST     = 11;
    localparam int LOOKAHEAD_RST = 33;
    localparam logic [3:0]  HI_SHIFT_RST  = 4'd3;
    localparam logic [7:0]  POS_HMASK_RST = 8'hE0;
    localparam logic [5:0]  SIZE_MASK_RST = 6'h1F;
    localparam logic [23:0] OUT_LIMIT_RST = 24'hFFFFFF;

    // token index value meaning "flag byte expected next"
    localparam logic [3:0] TOK_FLAG = 4'd8;

    typedef struct packed {
        logic [3:0]  window_log2;
        logic [11:0] lookahead;
        logic [3:0]  hi_shift;
        logic [7:0]  pos_high_mask;
        logic [5:0]  size_mask;
        logic [23:0] out_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/lzss_cfg_regs.sv =====
// ============================================================================
// lzss_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ============================================================================
`default_nettype none

module lzss_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [lzss_pkg::CFG_IDX_W-1:0]     i_index,
    input  wire logic [lzss_pkg::CFG_DATA_W-1:0]    i_data,
    output logic                                    o_ready,
    output lzss_pkg::t_cfg                          o_cfg
);

    lzss_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_log2   <= 4'(lzss_pkg::WLOG2_RST);
            r_cfg.lookahead     <= 12'(lzss_pkg::LOOKAHEAD_RST);
            r_cfg.hi_shift      <= lzss_pkg::HI_SHIFT_RST;
            r_cfg.pos_high_mask <= lzss_pkg::POS_HMASK_RST;
            r_cfg.size_mask     <= lzss_pkg::SIZE_MASK_RST;
            r_cfg.out_limit     <= lzss_pkg::OUT_LIMIT_RST;
        end else if (i_valid && o_ready) begin
            case (i_index)
                lzss_pkg::CFG_WINDOW_LOG2:   r_cfg.window_log2   <= i_data[3:0];
                lzss_pkg::CFG_LOOKAHEAD:     r_cfg.lookahead     <= i_data[11:0];
                lzss_pkg::CFG_HI_SHIFT:      r_cfg.hi_shift      <= i_data[3:0];
                lzss_pkg::CFG_POS_HIGH_MASK: r_cfg.pos_high_mask <= i_data[7:0];
                lzss_pkg::CFG_SIZE_MASK:     r_cfg.size_mask     <= i_data[5:0];
                lzss_pkg::CFG_OUT_LIMIT:     r_cfg.out_limit     <= i_data[23:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzss_ring_ram.sv =====
// ============================================================================
// lzss_ring_ram
// History ring: one write port, one registered read port, with write-to-read
// forwarding when a read hits the entry written in the same cycle.
// ============================================================================
`default_nettype none

module lzss_ring_ram #(
    parameter int AW = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic       r_fwd_hit;
    logic [7:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata    <= r_mem[i_raddr];
            r_fwd_hit  <= i_we && (i_waddr == i_raddr);
            r_fwd_data <= i_wdata;
        end
    end

    assign o_rdata = r_fwd_hit ? r_fwd_data : r_rdata;

endmodule

`default_nettype wire

// ===== rtl/lzss_ring_decompressor.sv =====
// Result path: a literal result is registered and can transfer in the cycle after
// its byte transfer; a match result is formed in ST_COPY, after ST_READ.
// Throughput: one compressed byte per cycle for flags and literals, and a match
// copy reads the ring one byte per cycle (len <= 65), both while the output is
// not stalled. Reset and begin: a clearing pass zeroes the ring, during which no
// item is taken (configuration writes still are).
// ============================================================================
// lzss_ring_decompressor
// LZSS decoder with a RAM history ring, emitting up to two bytes per result.
// ============================================================================
`default_nettype none

module lzss_ring_decompressor #(
    parameter int RING_DEPTH = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // compressed input
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_func,
    input  wire logic [7:0]                       i_in_byte,
    // decoded output
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [1:0]                            o_kind,
    output logic [7:0]                            o_byte_first,
    output logic [7:0]                            o_byte_second,
    output logic [1:0]                            o_byte_count,
    output logic [23:0]                           o_total_out,
    output logic                                  o_run_last,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lzss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lzss_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int AW      = $clog2(RING_DEPTH);
    localparam int RST_LG  = (lzss_pkg::WLOG2_RST > AW) ? AW : lzss_pkg::WLOG2_RST;
    localparam int RST_WIN = 1 << RST_LG;
    localparam logic [AW-1:0] RST_WP =
        AW'((RST_WIN - lzss_pkg::LOOKAHEAD_RST) & (RST_WIN - 1));

    lzss_pkg::t_cfg   cfg;
    lzss_pkg::t_state r_state, n_state;

    // control registers
    logic [AW-1:0] r_clr,      n_clr;
    logic [AW-1:0] r_wp,       n_wp;
    logic [7:0]    r_flag,     n_flag;
    logic [3:0]    r_tok,      n_tok;
    logic          r_pending,  n_pending;
    logic [7:0]    r_low,      n_low;
    logic [23:0]   r_produced, n_produced;
    logic          r_ovf,      n_ovf;
    logic [AW-1:0] r_raddr,    n_raddr;
    logic [6:0]    r_remain,   n_remain;
    logic          r_slot_full, n_slot_full;
    logic          r_out_valid, n_out_valid;

    // payload registers
    logic [7:0]    r_slot_byte, n_slot_byte;
    logic [1:0]    r_kind,   n_kind;
    logic [7:0]    r_b0,     n_b0;
    logic [7:0]    r_b1,     n_b1;
    logic [1:0]    r_cnt,    n_cnt;
    logic [23:0]   r_total,  n_total;
    logic          r_last,   n_last;

    // ring port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // derived values
    logic [4:0]    w_win_lg;
    logic [AW-1:0] w_mask;
    logic [16:0]   w_neg_la;
    logic [AW-1:0] w_begin_wp;
    logic [22:0]   w_pos_hi;
    logic [AW-1:0] w_pos;
    logic [6:0]    w_len;
    logic [AW-1:0] w_wp_m;
    logic [AW-1:0] w_wp_inc;
    logic [AW-1:0] w_raddr_inc;
    logic [23:0]   w_prod_inc;
    logic          w_at_limit;
    logic          w_out_free;
    logic          w_in_acc;
    logic          w_match_go;
    logic          w_ovf_next;
    logic          w_done;
    logic          w_closing;
    logic          w_consume;

    lzss_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    lzss_ring_ram #(
        .AW (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // window clamps to the ring size
    assign w_win_lg   = (5'(cfg.window_log2) > 5'(AW)) ? 5'(AW) : 5'(cfg.window_log2);
    assign w_mask     = ~({AW{1'b1}} << w_win_lg);
    assign w_neg_la   = 17'd0 - 17'(cfg.lookahead);
    assign w_begin_wp = w_neg_la[AW-1:0] & w_mask;

    assign w_pos_hi   = 23'(i_in_byte & cfg.pos_high_mask) << cfg.hi_shift;
    assign w_pos      = (w_pos_hi[AW-1:0] | AW'(r_low)) & w_mask;
    assign w_len      = 7'(i_in_byte[5:0] & cfg.size_mask) + 7'd2;

    assign w_wp_m      = r_wp & w_mask;
    assign w_wp_inc    = AW'(w_wp_m + AW'(1)) & w_mask;
    assign w_raddr_inc = AW'(r_raddr + AW'(1)) & w_mask;
    assign w_prod_inc  = r_produced + 24'd1;
    assign w_at_limit  = r_produced >= cfg.out_limit;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == lzss_pkg::ST_IDLE) && w_out_free);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_match_go = w_in_acc && (i_func == lzss_pkg::FUNC_BYTE) && !r_ovf
                        && !r_tok[3] && r_pending && !w_at_limit;

    // copy step: the next byte would cross the limit, or the match is finished
    assign w_ovf_next = (r_remain != 7'd1) && (w_prod_inc >= cfg.out_limit);
    assign w_done     = (r_remain == 7'd1) || w_ovf_next;
    assign w_closing  = r_slot_full || w_done;
    assign w_consume  = !w_closing || w_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzss_pkg::ST_CLEAR: begin
                if (&r_clr) begin
                    n_state = lzss_pkg::ST_IDLE;
                end
            end
            lzss_pkg::ST_IDLE: begin
                if (w_in_acc && (i_func == lzss_pkg::FUNC_BEGIN)) begin
                    n_state = lzss_pkg::ST_CLEAR;
                end else if (w_match_go) begin
                    n_state = lzss_pkg::ST_READ;
                end
            end
            lzss_pkg::ST_READ: begin
                n_state = lzss_pkg::ST_COPY;
            end
            lzss_pkg::ST_COPY: begin
                if (w_consume && w_done) begin
                    n_state = lzss_pkg::ST_IDLE;
                end
            end
            default: n_state = lzss_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_clr       = r_clr;
        n_wp        = r_wp;
        n_flag      = r_flag;
        n_tok       = r_tok;
        n_pending   = r_pending;
        n_low       = r_low;
        n_produced  = r_produced;
        n_ovf       = r_ovf;
        n_raddr     = r_raddr;
        n_remain    = r_remain;
        n_slot_full = r_slot_full;
        n_slot_byte = r_slot_byte;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_waddr   = w_wp_m;
        ram_wdata   = i_in_byte;
        ram_re      = 1'b0;
        ram_raddr   = r_raddr;

        case (r_state)
            lzss_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'd0;
                n_clr     = AW'(r_clr + AW'(1));
            end
            lzss_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_func)
                        lzss_pkg::FUNC_BEGIN: begin
                            n_clr       = '0;
                            n_wp        = w_begin_wp;
                            n_flag      = 8'd0;
                            n_tok       = lzss_pkg::TOK_FLAG;
                            n_pending   = 1'b0;
                            n_low       = 8'd0;
                            n_produced  = 24'd0;
                            n_ovf       = 1'b0;
                        end
                        lzss_pkg::FUNC_END: begin
                            n_out_valid = 1'b1;
                            n_kind      = r_ovf ? lzss_pkg::KIND_END_OVF
                                                : lzss_pkg::KIND_END_OK;
                            n_b0        = 8'd0;
                            n_b1        = 8'd0;
                            n_cnt       = 2'd0;
                            n_total     = r_produced;
                            n_last      = 1'b1;
                            n_tok       = lzss_pkg::TOK_FLAG;
                            n_pending   = 1'b0;
                        end
                        lzss_pkg::FUNC_BYTE: begin
                            if (!r_ovf) begin
                                if (r_tok[3]) begin
                                    n_flag = i_in_byte;
                                    n_tok  = 4'd0;
                                end else if (r_pending) begin
                                    n_pending = 1'b0;
                                    n_tok     = r_tok + 4'd1;
                                    if (w_at_limit) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_raddr  = w_pos;
                                        n_remain = w_len;
                                    end
                                end else if (r_flag[r_tok[2:0]]) begin
                                    n_tok = r_tok + 4'd1;
                                    if (w_at_limit) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        ram_we      = 1'b1;
                                        n_wp        = w_wp_inc;
                                        n_produced  = w_prod_inc;
                                        n_out_valid = 1'b1;
                                        n_kind      = lzss_pkg::KIND_DATA;
                                        n_b0        = i_in_byte;
                                        n_b1        = 8'd0;
                                        n_cnt       = 2'd1;
                                        n_total     = 24'd0;
                                        n_last      = 1'b1;
                                    end
                                end else begin
                                    n_pending = 1'b1;
                                    n_low     = i_in_byte;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            lzss_pkg::ST_READ: begin
                ram_re  = 1'b1;
                n_raddr = w_raddr_inc;
            end
            lzss_pkg::ST_COPY: begin
                if (w_consume) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    n_wp       = w_wp_inc;
                    n_produced = w_prod_inc;
                    n_remain   = r_remain - 7'd1;
                    if (w_closing) begin
                        n_out_valid = 1'b1;
                        n_kind      = lzss_pkg::KIND_DATA;
                        n_total     = 24'd0;
                        n_last      = w_done;
                        n_slot_full = 1'b0;
                        if (r_slot_full) begin
                            n_b0  = r_slot_byte;
                            n_b1  = ram_rdata;
                            n_cnt = 2'd2;
                        end else begin
                            n_b0  = ram_rdata;
                            n_b1  = 8'd0;
                            n_cnt = 2'd1;
                        end
                    end else begin
                        n_slot_full = 1'b1;
                        n_slot_byte = ram_rdata;
                    end
                    if (w_ovf_next) begin
                        n_ovf = 1'b1;
                    end
                    // fetch the next source byte alongside this write
                    if (!w_done) begin
                        ram_re  = 1'b1;
                        n_raddr = w_raddr_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzss_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_wp        <= RST_WP;
            r_flag      <= 8'd0;
            r_tok       <= lzss_pkg::TOK_FLAG;
            r_pending   <= 1'b0;
            r_low       <= 8'd0;
            r_produced  <= 24'd0;
            r_ovf       <= 1'b0;
            r_raddr     <= '0;
            r_remain    <= 7'd0;
            r_slot_full <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wp        <= n_wp;
            r_flag      <= n_flag;
            r_tok       <= n_tok;
            r_pending   <= n_pending;
            r_low       <= n_low;
            r_produced  <= n_produced;
            r_ovf       <= n_ovf;
            r_raddr     <= n_raddr;
            r_remain    <= n_remain;
            r_slot_full <= n_slot_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_byte <= n_slot_byte;
        r_kind      <= n_kind;
        r_b0        <= n_b0;
        r_b1        <= n_b1;
        r_cnt       <= n_cnt;
        r_total     <= n_total;
        r_last      <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_byte_first  = r_b0;
    assign o_byte_second = r_b1;
    assign o_byte_count  = r_cnt;
    assign o_total_out   = r_total;
    assign o_run_last    = r_last;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lzss_ring_decompressor. A queue-fed driver sends
// compressed bytes, begin and end items; every accepted item runs through a
// local decode model whose results are compared with the output channel in
// order. Configuration is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb;

    localparam int RING_DEPTH = 4096;
    localparam int IDLE_PCT   = 28;
    localparam int CFG_IW     = lzss_pkg::CFG_IDX_W;
    localparam int CFG_DW     = lzss_pkg::CFG_DATA_W;
    // func code the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
    } t_comp_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_first;
        logic [7:0]  byte_second;
        logic [1:0]  byte_count;
        logic [23:0] total_out;
        logic        run_last;
    } t_dec_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [1:0]           in_func     = lzss_pkg::FUNC_BEGIN;
    logic [7:0]           in_byte     = 8'h00;
    logic                 out_stall   = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IW-1:0]    cfg_index   = lzss_pkg::CFG_WINDOW_LOG2;
    logic [CFG_DW-1:0]    cfg_data    = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_first;
    logic [7:0]  o_byte_second;
    logic [1:0]  o_byte_count;
    logic [23:0] o_total_out;
    logic        o_run_last;
    logic        o_cfg_ready;

    lzss_ring_decompressor #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (in_func),
        .i_in_byte     (in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_kind        (o_kind),
        .o_byte_first  (o_byte_first),
        .o_byte_second (o_byte_second),
        .o_byte_count  (o_byte_count),
        .o_total_out   (o_total_out),
        .o_run_last    (o_run_last),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    // decode model state
    lzss_pkg::t_cfg cfg_sh;
    logic [7:0]  ring_mem [0:RING_DEPTH-1];
    int unsigned wr_ptr;
    logic [7:0]  flags;
    logic [3:0]  tok_idx;
    logic        pend;
    logic [7:0]  low_byte;
    logic [23:0] produced;
    logic        ovf_seen;

    t_comp_item  comp_feed [$];
    t_dec_result item_res [$];
    t_dec_result dec_expected [$];

    int          err_count = 0;
    int          cyc = 0;
    bit          quiet;
    logic        in_fire = 1'b0;
    t_comp_item  nxt;
    t_dec_result got_r;
    t_dec_result want_r;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // decode model
    // ------------------------------------------------------------------------
    function automatic int unsigned win_bytes();
        int unsigned w;
        w = 1 << cfg_sh.window_log2;
        while (w > RING_DEPTH) w = w >> 1;
        return w;
    endfunction

    function automatic void restart_stream();
        int unsigned w;
        w = win_bytes();
        for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = 8'h00;
        wr_ptr   = (w - 32'(cfg_sh.lookahead)) & (w - 1);
        flags    = 8'h00;
        tok_idx  = lzss_pkg::TOK_FLAG;
        pend     = 1'b0;
        low_byte = 8'h00;
        produced = 24'd0;
        ovf_seen = 1'b0;
    endfunction

    // appends one decoded byte to the ring and the pending results
    function automatic bit push_decoded(logic [7:0] c);
        int unsigned w;
        int unsigned wp;
        t_dec_result r;
        w = win_bytes();
        if (produced >= cfg_sh.out_limit) begin
            ovf_seen = 1'b1;
            return 1'b0;
        end
        produced = produced + 24'd1;
        wp = wr_ptr & (w - 1);
        ring_mem[wp] = c;
        wr_ptr = (wp + 1) & (w - 1);
        if (item_res.size() > 0 && item_res[item_res.size()-1].byte_count == 2'd1) begin
            r = item_res.pop_back();
            r.byte_second = c;
            r.byte_count  = 2'd2;
        end else begin
            r = '0;
            r.kind       = lzss_pkg::KIND_DATA;
            r.byte_first = c;
            r.byte_count = 2'd1;
        end
        item_res.push_back(r);
        return 1'b1;
    endfunction

    task automatic decode_item(input logic [1:0] fn, input logic [7:0] b);
        int unsigned w, hb, pos, len, idx, k;
        t_dec_result r;
        item_res.delete();
        case (fn)
            lzss_pkg::FUNC_BEGIN: restart_stream();
            lzss_pkg::FUNC_END: begin
                r = '0;
                r.kind      = ovf_seen ? lzss_pkg::KIND_END_OVF : lzss_pkg::KIND_END_OK;
                r.total_out = produced;
                item_res.push_back(r);
                tok_idx = lzss_pkg::TOK_FLAG;
                pend    = 1'b0;
            end
            lzss_pkg::FUNC_BYTE: begin
                if (!ovf_seen) begin
                    if (tok_idx >= lzss_pkg::TOK_FLAG) begin
                        flags   = b;
                        tok_idx = 4'd0;
                    end else if (pend) begin
                        w   = win_bytes();
                        hb  = 32'(b & cfg_sh.pos_high_mask);
                        pos = 32'(low_byte) | (hb << cfg_sh.hi_shift);
                        hb  = 32'(b[5:0] & cfg_sh.size_mask);
                        len = hb + 2;
                        pend    = 1'b0;
                        tok_idx = tok_idx + 4'd1;
                        // byte-by-byte so overlapping copies see their own output
                        for (k = 0; k < len; k++) begin
                            idx = (pos + k) & (w - 1);
                            if (!push_decoded(ring_mem[idx])) break;
                        end
                    end else if (flags[tok_idx[2:0]]) begin
                        tok_idx = tok_idx + 4'd1;
                        void'(push_decoded(b));
                    end else begin
                        pend     = 1'b1;
                        low_byte = b;
                    end
                end
            end
            default: ;
        endcase
        if (item_res.size() > 0) begin
            r = item_res.pop_back();
            r.run_last = 1'b1;
            item_res.push_back(r);
        end
        while (item_res.size() > 0) dec_expected.push_back(item_res.pop_front());
    endtask

    task automatic log_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // driver: new input at the falling edge once the last one transferred
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        cyc <= cyc + 1;
        quiet = (cyc % 4000) >= 3200;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (comp_feed.size() > 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                nxt = comp_feed.pop_front();
                in_valid <= 1'b1;
                in_func  <= nxt.func;
                in_byte  <= nxt.data;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------------
    // monitor: transfers at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_fire <= in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !out_stall) begin
                got_r = {o_kind, o_byte_first, o_byte_second, o_byte_count,
                         o_total_out, o_run_last};
                if (dec_expected.size() == 0) begin
                    log_mismatch($sformatf("unexpected result kind %0d", o_kind));
                end else begin
                    want_r = dec_expected.pop_front();
                    if (got_r !== want_r)
                        log_mismatch($sformatf({"kind %0d/%0d bytes %h %h/%h %h",
                            " cnt %0d/%0d total %0d/%0d last %0d/%0d"},
                            got_r.kind, want_r.kind, got_r.byte_first, got_r.byte_second,
                            want_r.byte_first, want_r.byte_second, got_r.byte_count,
                            want_r.byte_count, got_r.total_out, want_r.total_out,
                            got_r.run_last, want_r.run_last));
                end
            end
            if (in_valid && !o_in_stall) decode_item(in_func, in_byte);
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    lzss_pkg::CFG_WINDOW_LOG2:   cfg_sh.window_log2   = cfg_data[3:0];
                    lzss_pkg::CFG_LOOKAHEAD:     cfg_sh.lookahead     = cfg_data[11:0];
                    lzss_pkg::CFG_HI_SHIFT:      cfg_sh.hi_shift      = cfg_data[3:0];
                    lzss_pkg::CFG_POS_HIGH_MASK: cfg_sh.pos_high_mask = cfg_data[7:0];
                    lzss_pkg::CFG_SIZE_MASK:     cfg_sh.size_mask     = cfg_data[5:0];
                    lzss_pkg::CFG_OUT_LIMIT:     cfg_sh.out_limit     = cfg_data[23:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [1:0] f, logic [7:0] d);
        t_comp_item it;
        it.func = f;
        it.data = d;
        comp_feed.push_back(it);
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx,
                             input logic [CFG_DW-1:0] val);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic [3:0] wl, input logic [11:0] la,
                              input logic [3:0] sh, input logic [7:0] hm,
                              input logic [5:0] lm, input logic [23:0] lim);
        write_reg(lzss_pkg::CFG_WINDOW_LOG2,   CFG_DW'(wl));
        write_reg(lzss_pkg::CFG_LOOKAHEAD,     CFG_DW'(la));
        write_reg(lzss_pkg::CFG_HI_SHIFT,      CFG_DW'(sh));
        write_reg(lzss_pkg::CFG_POS_HIGH_MASK, CFG_DW'(hm));
        write_reg(lzss_pkg::CFG_SIZE_MASK,     CFG_DW'(lm));
        write_reg(lzss_pkg::CFG_OUT_LIMIT,     lim);
    endtask

    // mostly well-formed streams with random content, some stray items
    task automatic add_random(input int n_items);
        int added, ngrp, ntok;
        logic [7:0] flg;
        added = 0;
        queue_item(lzss_pkg::FUNC_BEGIN, 8'($urandom));
        while (added < n_items) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0:       queue_item(lzss_pkg::FUNC_END, 8'($urandom));
                    1:       queue_item(FUNC_UNUSED, 8'($urandom));
                    default: queue_item(lzss_pkg::FUNC_BYTE, 8'($urandom));
                endcase
                added++;
            end else begin
                if ($urandom_range(3) == 0) queue_item(lzss_pkg::FUNC_BEGIN, 8'($urandom));
                ngrp = $urandom_range(1, 3);
                for (int g = 0; g < ngrp; g++) begin
                    flg = 8'($urandom);
                    queue_item(lzss_pkg::FUNC_BYTE, flg);
                    added++;
                    ntok = (g == ngrp - 1) ? $urandom_range(0, 8) : 8;
                    for (int t = 0; t < ntok; t++) begin
                        queue_item(lzss_pkg::FUNC_BYTE, 8'($urandom));
                        added++;
                        // now and then leave the last match half received
                        if (!flg[t] && !(g == ngrp - 1 && t == ntok - 1 &&
                                         $urandom_range(3) == 0)) begin
                            queue_item(lzss_pkg::FUNC_BYTE, 8'($urandom));
                            added++;
                        end
                    end
                end
                queue_item(lzss_pkg::FUNC_END, 8'($urandom));
                added++;
            end
        end
        queue_item(lzss_pkg::FUNC_END, 8'($urandom));
    endtask

    task automatic drain();
        while (comp_feed.size() > 0 || in_valid) @(posedge i_clk);
        while (dec_expected.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        cfg_sh.window_log2   = 4'(lzss_pkg::WLOG2_RST);
        cfg_sh.lookahead     = 12'(lzss_pkg::LOOKAHEAD_RST);
        cfg_sh.hi_shift      = lzss_pkg::HI_SHIFT_RST;
        cfg_sh.pos_high_mask = lzss_pkg::POS_HMASK_RST;
        cfg_sh.size_mask     = lzss_pkg::SIZE_MASK_RST;
        cfg_sh.out_limit     = lzss_pkg::OUT_LIMIT_RST;
        restart_stream();

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, decoding straight into the reset window
        queue_item(lzss_pkg::FUNC_BYTE, 8'h55);    // alternating literal / match
        queue_item(lzss_pkg::FUNC_BYTE, 8'hFF);
        queue_item(lzss_pkg::FUNC_BYTE, 8'hDF);    // longest copy, overlaps itself
        queue_item(lzss_pkg::FUNC_BYTE, 8'hFF);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h00);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h00);    // shortest copy from position 0
        queue_item(lzss_pkg::FUNC_BYTE, 8'h00);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h81);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h3C);    // match cut off by end
        queue_item(lzss_pkg::FUNC_END, 8'hFF);
        queue_item(FUNC_UNUSED, 8'hFF);
        queue_item(lzss_pkg::FUNC_BYTE, 8'hFE);    // continues without begin
        queue_item(lzss_pkg::FUNC_BYTE, 8'hE5);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h03);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h7F);
        queue_item(lzss_pkg::FUNC_END, 8'h00);
        queue_item(lzss_pkg::FUNC_BEGIN, 8'hA5);
        queue_item(lzss_pkg::FUNC_BYTE, 8'hFF);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h01);
        queue_item(lzss_pkg::FUNC_BYTE, 8'h80);
        queue_item(lzss_pkg::FUNC_END, 8'h00);
        drain();

        set_config(4'd4, 12'd0, 4'd0, 8'h00, 6'h00, 24'd0);   // overflow at once
        add_random(15);
        drain();
        set_config(4'd12, 12'd4095, 4'd8, 8'hFF, 6'h3F, 24'hFFFFFF);
        add_random(35);
        drain();
        set_config(4'd15, 12'd18, 4'd4, 8'hF0, 6'h0F, 24'd150);
        add_random(35);
        drain();
        set_config(4'd2, 12'd3000, 4'd2, 8'h3C, 6'h03, 24'hFFFFFF);
        add_random(30);
        drain();
        set_config(4'd10, 12'd48, 4'd2, 8'hC0, 6'h3F, 24'd1024);
        add_random(35);
        drain();
        set_config(4'd0, 12'd1, 4'd15, 8'h81, 6'h10, 24'd700);
        add_random(30);
        drain();
        repeat (2) begin
            set_config(4'($urandom), 12'($urandom), 4'($urandom), 8'($urandom),
                       6'($urandom),
                       $urandom_range(1) ? 24'hFFFFFF : 24'($urandom_range(60, 2000)));
            add_random(25);
            drain();
        end
        set_config(4'd11, 12'd33, 4'd3, 8'hE0, 6'h1F, 24'hFFFFFF);
        add_random(30);
        drain();

        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
